>>> rtl/rrwt_pkg.sv
package rrwt_pkg;

  // Job store sizing and field widths.
  localparam int unsigned MaxJobs   = 16;
  localparam int unsigned JobBits   = 4;
  localparam int unsigned CountBits = 5;
  localparam int unsigned BurstBits = 8;
  localparam int unsigned TimeBits  = 12;
  localparam int unsigned SumBits   = 16;
  localparam int unsigned CfgBits   = 8;

  typedef logic [JobBits-1:0]   job_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [BurstBits-1:0] burst_t;
  typedef logic [TimeBits-1:0]  time_t;
  typedef logic [SumBits-1:0]   sum_t;
  typedef logic [CfgBits-1:0]   cfg_data_t;
  typedef logic                 cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_QUANTUM   = 1'b0;
  localparam cfg_idx_t CFG_JOB_COUNT = 1'b1;

  // Register reset values.
  localparam burst_t QUANTUM_RESET   = 8'd3;
  localparam count_t JOB_COUNT_RESET = 5'd10;

endpackage

>>> rtl/rrwt_div.sv
// Restoring divider: one quotient bit per cycle. The sum is divided by the job
// count, which is at most 16, so the partial remainder stays narrow.
module rrwt_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  rrwt_pkg::sum_t        dividend_i,
  input  rrwt_pkg::count_t      divisor_i,
  output logic                  done_o,
  output rrwt_pkg::sum_t        quotient_o
);

  localparam int unsigned StepBits = $clog2(rrwt_pkg::SumBits);

  rrwt_pkg::sum_t           dvd_q;
  rrwt_pkg::count_t         rem_q;
  rrwt_pkg::count_t         dsr_q;
  logic [StepBits-1:0]      cnt_q;
  logic                     run_q;
  logic                     done_q;
  logic [rrwt_pkg::CountBits:0] shifted;
  logic [rrwt_pkg::CountBits:0] diff;
  logic                     qbit;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted = {rem_q, dvd_q[rrwt_pkg::SumBits-1]};
    diff    = shifted - {1'b0, dsr_q};
    qbit    = (shifted >= {1'b0, dsr_q});
  end

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + StepBits'(1);
        if (cnt_q == StepBits'(rrwt_pkg::SumBits - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register collects the quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[rrwt_pkg::SumBits-2:0], qbit};
      rem_q <= qbit ? diff[rrwt_pkg::CountBits-1:0] : shifted[rrwt_pkg::CountBits-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

>>> rtl/round_robin_wait_times.sv
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+----------
// job in    | start, busy, burst_time_i                      | in, busy out
// result    | result_valid_o, job_index_o, wait_time_o,      | out
//           | turnaround_o, average_wait_o,                  |
//           | average_turnaround_o, last_o                   |
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i               | in
//
// A word that does not complete the load is stored and busy stays low. The word
// that completes it starts the run: the round robin loop visits the jobs in turn
// (a finished job is still visited but skipped), then two divisions (a start,
// the quotient steps and a done pulse) give the averages, then one result per
// cycle comes out, one per job of the run. Results come as one-cycle strobes on
// result_valid_o and cannot be stalled. After reset no run is in progress.
module round_robin_wait_times (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  rrwt_pkg::burst_t         burst_time_i,
  input  logic                     cfg_we_i,
  input  rrwt_pkg::cfg_idx_t       cfg_idx_i,
  input  rrwt_pkg::cfg_data_t      cfg_wdata_i,
  output logic                     result_valid_o,
  output rrwt_pkg::job_t           job_index_o,
  output rrwt_pkg::time_t          wait_time_o,
  output rrwt_pkg::time_t          turnaround_o,
  output rrwt_pkg::time_t          average_wait_o,
  output rrwt_pkg::time_t          average_turnaround_o,
  output logic                     last_o
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SIM  = 3'd1;
  localparam logic [2:0] ST_DIVW = 3'd2;
  localparam logic [2:0] ST_DIVT = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam int unsigned TB = rrwt_pkg::TimeBits;
  localparam int unsigned BB = rrwt_pkg::BurstBits;
  localparam int unsigned CB = rrwt_pkg::CountBits;

  // Configuration registers.
  rrwt_pkg::burst_t  quantum_q;
  rrwt_pkg::count_t  job_count_q;

  // Job stores.
  rrwt_pkg::burst_t  burst_mem [rrwt_pkg::MaxJobs];
  rrwt_pkg::burst_t  remain_mem[rrwt_pkg::MaxJobs];
  rrwt_pkg::time_t   wait_mem  [rrwt_pkg::MaxJobs];

  // Sequencer state.
  logic [2:0]                   state_q;
  logic [rrwt_pkg::MaxJobs-1:0] fin_q;
  rrwt_pkg::count_t             fin_cnt_q;
  rrwt_pkg::count_t             loaded_q;
  rrwt_pkg::time_t              elapsed_q;
  rrwt_pkg::job_t               idx_q;
  rrwt_pkg::sum_t               sum_w_q;
  rrwt_pkg::sum_t               sum_t_q;
  logic                         div_start_q;
  rrwt_pkg::time_t              avg_w_q;
  rrwt_pkg::time_t              avg_t_q;

  // Result registers.
  logic                         valid_q;
  rrwt_pkg::job_t               out_idx_q;
  rrwt_pkg::time_t              out_wait_q;
  rrwt_pkg::time_t              out_turn_q;
  rrwt_pkg::time_t              out_avg_w_q;
  rrwt_pkg::time_t              out_avg_t_q;
  logic                         out_last_q;

  logic                         accept;
  rrwt_pkg::count_t             n_eff;
  rrwt_pkg::job_t               n_m1;
  rrwt_pkg::burst_t             q_eff;
  rrwt_pkg::job_t               slot;
  rrwt_pkg::count_t             slot_next;
  rrwt_pkg::burst_t             rem_cur;
  rrwt_pkg::burst_t             burst_cur;
  logic                         run_full;
  rrwt_pkg::burst_t             step;
  rrwt_pkg::time_t              elapsed_new;
  rrwt_pkg::time_t              wait_new;
  logic                         last_job;
  logic                         all_done;
  rrwt_pkg::time_t              turn_cur;
  rrwt_pkg::sum_t               div_dividend;
  logic                         div_done;
  rrwt_pkg::sum_t               div_quot;

  assign accept = start && (state_q == ST_LOAD);
  assign busy   = (state_q != ST_LOAD);

  // Clamp the configuration to usable values.
  always_comb begin
    if (job_count_q == '0) begin
      n_eff = CB'(1);
    end else if (job_count_q > CB'(rrwt_pkg::MaxJobs)) begin
      n_eff = CB'(rrwt_pkg::MaxJobs);
    end else begin
      n_eff = job_count_q;
    end
    n_m1  = rrwt_pkg::JobBits'(n_eff - CB'(1));
    q_eff = (quantum_q == '0) ? BB'(1) : quantum_q;
  end

  // Load slot, saturating at the last store entry.
  always_comb begin
    slot      = (loaded_q >= CB'(rrwt_pkg::MaxJobs)) ? rrwt_pkg::JobBits'(rrwt_pkg::MaxJobs - 1)
                                                     : loaded_q[rrwt_pkg::JobBits-1:0];
    slot_next = {1'b0, slot} + CB'(1);
  end

  // One round robin visit: run a quantum or finish the job.
  always_comb begin
    rem_cur     = remain_mem[idx_q];
    burst_cur   = burst_mem[idx_q];
    run_full    = (rem_cur > q_eff);
    step        = run_full ? q_eff : rem_cur;
    elapsed_new = elapsed_q + TB'(step);
    wait_new    = elapsed_new - TB'(burst_cur);
    last_job    = (idx_q == n_m1);
    all_done    = (fin_cnt_q + CB'(1) == n_eff);
    turn_cur    = wait_mem[idx_q] + TB'(burst_cur);
  end

  // Divider operand: sum of waits first, then sum of turnarounds.
  assign div_dividend = (state_q == ST_DIVW) ? sum_w_q : sum_t_q;

  rrwt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= rrwt_pkg::QUANTUM_RESET;
      job_count_q <= rrwt_pkg::JOB_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrwt_pkg::CFG_QUANTUM:   quantum_q   <= cfg_wdata_i;
        rrwt_pkg::CFG_JOB_COUNT: job_count_q <= cfg_wdata_i[CB-1:0];
        default: ;
      endcase
    end
  end

  // Job stores: loaded on accepted words, updated on each visit to an unfinished job.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      burst_mem[slot]  <= burst_time_i;
      remain_mem[slot] <= burst_time_i;
    end else if (state_q == ST_SIM && !fin_q[idx_q]) begin
      remain_mem[idx_q] <= rem_cur - step;
      if (!run_full) begin
        wait_mem[idx_q] <= wait_new;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fin_q       <= '0;
      fin_cnt_q   <= '0;
      loaded_q    <= '0;
      elapsed_q   <= '0;
      idx_q       <= '0;
      sum_w_q     <= '0;
      sum_t_q     <= '0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            loaded_q <= slot_next;
            if (slot_next >= n_eff) begin
              state_q <= ST_SIM;
              idx_q   <= '0;
            end
          end
        end
        ST_SIM: begin
          if (!fin_q[idx_q]) begin
            elapsed_q <= elapsed_new;
            if (!run_full) begin
              fin_q[idx_q] <= 1'b1;
              fin_cnt_q    <= fin_cnt_q + CB'(1);
              sum_w_q      <= sum_w_q + rrwt_pkg::SumBits'(wait_new);
              sum_t_q      <= sum_t_q + rrwt_pkg::SumBits'(elapsed_new);
              if (all_done) begin
                state_q     <= ST_DIVW;
                div_start_q <= 1'b1;
              end
            end
          end
          idx_q <= last_job ? '0 : idx_q + rrwt_pkg::JobBits'(1);
        end
        ST_DIVW: begin
          if (div_done) begin
            state_q     <= ST_DIVT;
            div_start_q <= 1'b1;
          end
        end
        ST_DIVT: begin
          if (div_done) begin
            state_q <= ST_EMIT;
            idx_q   <= '0;
          end
        end
        ST_EMIT: begin
          idx_q <= idx_q + rrwt_pkg::JobBits'(1);
          if (last_job) begin
            // Run complete: clear the run state for the next load.
            state_q   <= ST_LOAD;
            fin_q     <= '0;
            fin_cnt_q <= '0;
            loaded_q  <= '0;
            elapsed_q <= '0;
            sum_w_q   <= '0;
            sum_t_q   <= '0;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // Averages captured from the divider.
  always_ff @(posedge clk_i) begin
    if (div_done && state_q == ST_DIVW) begin
      avg_w_q <= TB'(div_quot);
    end
    if (div_done && state_q == ST_DIVT) begin
      avg_t_q <= TB'(div_quot);
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_EMIT);
    end
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      out_idx_q   <= idx_q;
      out_wait_q  <= wait_mem[idx_q];
      out_turn_q  <= turn_cur;
      out_avg_w_q <= last_job ? avg_w_q : '0;
      out_avg_t_q <= last_job ? avg_t_q : '0;
      out_last_q  <= last_job;
    end
  end

  assign result_valid_o       = valid_q;
  assign job_index_o          = out_idx_q;
  assign wait_time_o          = out_wait_q;
  assign turnaround_o         = out_turn_q;
  assign average_wait_o       = out_avg_w_q;
  assign average_turnaround_o = out_avg_t_q;
  assign last_o               = out_last_q;

endmodule
